[rtl/core/particle_distance_table_unit_assert.svh]
// Assertion macros used by the distance table top level
`ifndef PARTICLE_DISTANCE_TABLE_UNIT_ASSERT_SVH
`define PARTICLE_DISTANCE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define PDT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("distance table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define PDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("distance table: next-cycle check failed");

`endif

[rtl/core/pdt_pkg.sv]
// Shared types, widths and codes of the particle distance table
package pdt_pkg;

  localparam int CMD_W       = 2;
  localparam int INDEX_W     = 6;
  localparam int POS_W       = 24;
  localparam int ENTRY_W     = 3 * POS_W;
  localparam int DELTA_W     = POS_W + 1;
  localparam int DSQ_W       = 2 * DELTA_W;
  localparam int ROOT_W      = DELTA_W;
  localparam int ROOT_STEPS  = ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int ECOUNT_W    = 7;
  localparam int ICOUNT_W    = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam int MAX_ELECTRONS_DEF = 64;
  localparam int MAX_IONS_DEF      = 32;

  localparam logic [ECOUNT_W-1:0] ELECTRON_COUNT_RESET = 7'd64;
  localparam logic [ICOUNT_W-1:0] ION_COUNT_RESET      = 6'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_ELECTRON = 2'd0,
    CMD_SET_ION      = 2'd1,
    CMD_QUERY_EI     = 2'd2,
    CMD_QUERY_EE     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ELECTRON_COUNT = 1'd0,
    REG_ION_COUNT      = 1'd1
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;      // zero one entry of each table that is still being cleared
    logic accept;     // input word taken this cycle
    logic rd_hi;      // electron read address selects the higher index
    logic cap_a;      // capture first operand (and ion entry)
    logic cap_b;      // capture second electron operand
    logic diff;       // form displacements
    logic sq_step;    // one square / accumulate step
    logic root_init;  // load square root unit
    logic root_step;  // one square root digit
    logic load_out;   // move result into the output register
  } pdt_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic req_query;
    logic req_ok;
    logic sq_last;
    logic root_last;
  } pdt_sts_t;

endpackage

[rtl/core/pdt_if.sv]
// Request and response channel interfaces of the distance table
interface pdt_req_if;
  logic                               valid;
  logic                               ready;
  logic [pdt_pkg::CMD_W-1:0]          cmd;
  logic [pdt_pkg::INDEX_W-1:0]        index_a;
  logic [pdt_pkg::INDEX_W-1:0]        index_b;
  logic signed [pdt_pkg::POS_W-1:0]   pos_x;
  logic signed [pdt_pkg::POS_W-1:0]   pos_y;
  logic signed [pdt_pkg::POS_W-1:0]   pos_z;

  modport source (output valid, cmd, index_a, index_b, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, cmd, index_a, index_b, pos_x, pos_y, pos_z, output ready);
endinterface

interface pdt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               valid_index;
  logic signed [pdt_pkg::DELTA_W-1:0] delta_x;
  logic signed [pdt_pkg::DELTA_W-1:0] delta_y;
  logic signed [pdt_pkg::DELTA_W-1:0] delta_z;
  logic [pdt_pkg::DSQ_W-1:0]          dist_squared;
  logic [pdt_pkg::ROOT_W-1:0]         dist_res;

  modport source (output valid, valid_index, delta_x, delta_y, delta_z, dist_squared,
                  dist_res, input ready);
  modport sink   (input valid, valid_index, delta_x, delta_y, delta_z, dist_squared,
                  dist_res, output ready);
endinterface

[rtl/core/particle_distance_table_unit.sv]
// Top level of the particle distance table: position store and pair query unit
//
//  channel | role   | word contents
//  --------+--------+------------------------------------------------------------
//  req     | sink   | cmd, index_a, index_b, pos_x, pos_y, pos_z
//  rsp     | source | valid_index, delta_x/y/z, dist_squared, dist_res
//  cfg     | write  | cfg_wr_en, cfg_index, cfg_data (electron_count, ion_count)
//
//  A write word updates the table on the accept edge. A valid query steps
//  through accept, table reads on the electron table's one read port,
//  subtract, square/accumulate on the shared multiplier, square root load
//  and the two-bit-per-step square root, then the output register load.
//  A query with an index out of range goes from accept straight to the
//  output register load and reports all zero. After reset a clearing pass
//  zeroes both tables; req.ready stays low until it ends.
//  A stalled rsp holds its word; writes are still taken meanwhile, but the
//  next query holds in its load cycle with req.ready low until the slot frees.
module particle_distance_table_unit #(
  parameter int MAX_ELECTRONS = pdt_pkg::MAX_ELECTRONS_DEF,
  parameter int MAX_IONS      = pdt_pkg::MAX_IONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [pdt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  pdt_req_if.sink                         req,
  pdt_rsp_if.source                       rsp
);

`include "particle_distance_table_unit_assert.svh"

  pdt_pkg::pdt_ctl_t ctl;
  pdt_pkg::pdt_sts_t sts;
  logic              req_ready;
  logic              rsp_valid;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  // sequencer: owns handshakes and steps the datapath
  pdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid)
  );

  // tables, arithmetic and the output register
  pdt_datapath #(
    .MAX_ELECTRONS (MAX_ELECTRONS),
    .MAX_IONS      (MAX_IONS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (req.cmd),
    .index_a      (req.index_a),
    .index_b      (req.index_b),
    .pos_x        (req.pos_x),
    .pos_y        (req.pos_y),
    .pos_z        (req.pos_z),
    .ctl          (ctl),
    .sts          (sts),
    .valid_index  (rsp.valid_index),
    .delta_x      (rsp.delta_x),
    .delta_y      (rsp.delta_y),
    .delta_z      (rsp.delta_z),
    .dist_squared (rsp.dist_squared),
    .dist_res     (rsp.dist_res)
  );

  // hold off new words for the whole clearing pass
  `PDT_ASSERT_IMP(a_no_accept_in_clear, clk, rst, ctl.clear, !req.ready)
  // load the output register only into a free slot
  `PDT_ASSERT_IMP(a_load_into_free_slot, clk, rst, ctl.load_out, (!rsp.valid || rsp.ready))
  // a load always shows a word on the next cycle
  `PDT_ASSERT_NEXT(a_load_shows_word, clk, rst, ctl.load_out, rsp.valid)
  // the root is the floor square root of the reported squared distance
  `PDT_ASSERT_IMP(a_root_is_floor, clk, rst, rsp.valid, ((52'(rsp.dist_res) * 52'(rsp.dist_res) <= 52'(rsp.dist_squared)) && ((52'(rsp.dist_res) + 52'd1) * (52'(rsp.dist_res) + 52'd1) > 52'(rsp.dist_squared))))

endmodule

[rtl/core/pdt_ram.sv]
// Generic single-write, single-read RAM with registered read data
module pdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pdt_datapath.sv]
// Position tables, displacement, square/accumulate and square root datapath
module pdt_datapath #(
  parameter int MAX_ELECTRONS = pdt_pkg::MAX_ELECTRONS_DEF,
  parameter int MAX_IONS      = pdt_pkg::MAX_IONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [pdt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pdt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [pdt_pkg::CMD_W-1:0]           cmd,
  input  logic [pdt_pkg::INDEX_W-1:0]         index_a,
  input  logic [pdt_pkg::INDEX_W-1:0]         index_b,
  input  logic signed [pdt_pkg::POS_W-1:0]    pos_x,
  input  logic signed [pdt_pkg::POS_W-1:0]    pos_y,
  input  logic signed [pdt_pkg::POS_W-1:0]    pos_z,
  input  pdt_pkg::pdt_ctl_t                   ctl,
  output pdt_pkg::pdt_sts_t                   sts,
  output logic                                valid_index,
  output logic signed [pdt_pkg::DELTA_W-1:0]  delta_x,
  output logic signed [pdt_pkg::DELTA_W-1:0]  delta_y,
  output logic signed [pdt_pkg::DELTA_W-1:0]  delta_z,
  output logic [pdt_pkg::DSQ_W-1:0]           dist_squared,
  output logic [pdt_pkg::ROOT_W-1:0]          dist_res
);

  localparam int EAW   = (MAX_ELECTRONS > 1) ? $clog2(MAX_ELECTRONS) : 1;
  localparam int IAW   = (MAX_IONS > 1) ? $clog2(MAX_IONS) : 1;
  localparam int CLR_N = (MAX_ELECTRONS > MAX_IONS) ? MAX_ELECTRONS : MAX_IONS;
  localparam int CW    = $clog2(CLR_N);
  localparam int PW    = pdt_pkg::POS_W;
  localparam int DW    = pdt_pkg::DELTA_W;
  localparam int SW    = pdt_pkg::DSQ_W;
  localparam int RW    = pdt_pkg::ROOT_W;
  localparam int MW    = pdt_pkg::REM_W;
  localparam int RCW   = $clog2(pdt_pkg::ROOT_STEPS);

  // configuration
  logic [pdt_pkg::ECOUNT_W-1:0] electron_count;
  logic [pdt_pkg::ICOUNT_W-1:0] ion_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      electron_count <= pdt_pkg::ELECTRON_COUNT_RESET;
      ion_count      <= pdt_pkg::ION_COUNT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == pdt_pkg::REG_ELECTRON_COUNT) begin
        electron_count <= cfg_data;
      end else begin
        ion_count <= cfg_data[pdt_pkg::ICOUNT_W-1:0];
      end
    end
  end

  // index checks against the counts in effect
  logic a_in_e, a_in_i, b_in_e, b_in_i;
  logic is_ei, is_ee;

  assign a_in_e = (32'(index_a) < 32'(MAX_ELECTRONS)) && ({1'b0, index_a} < electron_count);
  assign b_in_e = (32'(index_b) < 32'(MAX_ELECTRONS)) && ({1'b0, index_b} < electron_count);
  assign a_in_i = (32'(index_a) < 32'(MAX_IONS)) && (index_a < ion_count);
  assign b_in_i = (32'(index_b) < 32'(MAX_IONS)) && (index_b < ion_count);
  assign is_ei  = (cmd == pdt_pkg::CMD_QUERY_EI);
  assign is_ee  = (cmd == pdt_pkg::CMD_QUERY_EE);

  assign sts.req_query = is_ei || is_ee;
  assign sts.req_ok    = (is_ei && a_in_e && b_in_i) || (is_ee && a_in_e && b_in_e);

  // latched query
  logic                        a_lt_b;
  logic [pdt_pkg::INDEX_W-1:0] lo_idx, hi_idx;
  logic                        q_ok, q_ee;
  logic [EAW-1:0]              q_lo, q_hi;
  logic [IAW-1:0]              q_ion;

  assign a_lt_b = index_a < index_b;
  assign lo_idx = a_lt_b ? index_a : index_b;
  assign hi_idx = a_lt_b ? index_b : index_a;

  always_ff @(posedge clk) begin
    if (ctl.accept && sts.req_query) begin
      q_ok  <= sts.req_ok;
      q_ee  <= is_ee;
      q_lo  <= is_ee ? EAW'(lo_idx) : EAW'(index_a);
      q_hi  <= EAW'(hi_idx);
      q_ion <= IAW'(index_b);
    end
  end

  // clearing pass counter
  logic [CW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt == CW'(CLR_N - 1));

  // position tables
  logic                          e_we, i_we;
  logic [EAW-1:0]                e_waddr, e_raddr;
  logic [IAW-1:0]                i_waddr;
  logic [pdt_pkg::ENTRY_W-1:0]   wdata, e_rdata, i_rdata;

  assign wdata   = ctl.clear ? '0 : {pos_x, pos_y, pos_z};
  assign e_we    = (ctl.clear && (32'(clr_cnt) < 32'(MAX_ELECTRONS)))
                || (ctl.accept && (cmd == pdt_pkg::CMD_SET_ELECTRON) && a_in_e);
  assign i_we    = (ctl.clear && (32'(clr_cnt) < 32'(MAX_IONS)))
                || (ctl.accept && (cmd == pdt_pkg::CMD_SET_ION) && a_in_i);
  assign e_waddr = ctl.clear ? EAW'(clr_cnt) : EAW'(index_a);
  assign i_waddr = ctl.clear ? IAW'(clr_cnt) : IAW'(index_a);
  assign e_raddr = ctl.rd_hi ? q_hi : q_lo;

  pdt_ram #(.WIDTH(pdt_pkg::ENTRY_W), .DEPTH(MAX_ELECTRONS)) u_electron_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  pdt_ram #(.WIDTH(pdt_pkg::ENTRY_W), .DEPTH(MAX_IONS)) u_ion_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (wdata),
    .raddr (q_ion),
    .rdata (i_rdata)
  );

  // operands and displacements
  logic [pdt_pkg::ENTRY_W-1:0] pa, pb;
  logic signed [DW-1:0]        dx, dy, dz;

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      pa <= e_rdata;
      pb <= i_rdata;
    end else if (ctl.cap_b && q_ee) begin
      pb <= e_rdata;
    end
    if (ctl.diff) begin
      dx <= $signed({pa[3*PW-1], pa[3*PW-1:2*PW]}) - $signed({pb[3*PW-1], pb[3*PW-1:2*PW]});
      dy <= $signed({pa[2*PW-1], pa[2*PW-1:PW]})   - $signed({pb[2*PW-1], pb[2*PW-1:PW]});
      dz <= $signed({pa[PW-1], pa[PW-1:0]})        - $signed({pb[PW-1], pb[PW-1:0]});
    end
  end

  // square and accumulate, one axis a cycle
  logic [1:0]           sq_idx;
  logic signed [DW-1:0] dsel;
  logic signed [SW-1:0] prod_s;
  logic [SW-1:0]        prod, dsq;

  always_comb begin
    case (sq_idx)
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
  end

  assign prod_s      = dsel * dsel;
  assign sts.sq_last = (sq_idx == 2'd3);

  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      sq_idx <= '0;
      dsq    <= '0;
    end else if (ctl.sq_step) begin
      sq_idx <= sq_idx + 1'b1;
      if (sq_idx != 2'd3) begin
        prod <= $unsigned(prod_s);
      end
      if (sq_idx != 2'd0) begin
        dsq <= dsq + prod;
      end
    end
  end

  // digit-by-digit square root, two radicand bits per step
  logic [SW-1:0]  rad;
  logic [MW-1:0]  rem, rem_sh, trial;
  logic [RW-1:0]  root;
  logic [RCW-1:0] root_cnt;
  logic           fits;

  assign rem_sh        = {rem[MW-3:0], rad[SW-1:SW-2]};
  assign trial         = {root, 2'b01};
  assign fits          = rem_sh >= trial;
  assign sts.root_last = (root_cnt == RCW'(pdt_pkg::ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (ctl.root_init) begin
      rad      <= dsq;
      rem      <= '0;
      root     <= '0;
      root_cnt <= '0;
    end else if (ctl.root_step) begin
      rad      <= {rad[SW-3:0], 2'b00};
      rem      <= fits ? (rem_sh - trial) : rem_sh;
      root     <= {root[RW-2:0], fits};
      root_cnt <= root_cnt + 1'b1;
    end
  end

  // output register; an out-of-range query reports all zero
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      valid_index  <= q_ok;
      delta_x      <= q_ok ? dx : '0;
      delta_y      <= q_ok ? dy : '0;
      delta_z      <= q_ok ? dz : '0;
      dist_squared <= q_ok ? dsq : '0;
      dist_res     <= q_ok ? root : '0;
    end
  end

endmodule

[rtl/core/pdt_ctrl.sv]
// Sequencer for clearing, table access, squaring and square root
module pdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              rsp_ready,
  input  pdt_pkg::pdt_sts_t sts,
  output pdt_pkg::pdt_ctl_t ctl,
  output logic              req_ready,
  output logic              rsp_valid
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_RD3,
    S_DIFF,
    S_SQ,
    S_ROOT_INIT,
    S_ROOT,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign req_ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.accept = req_valid;
        if (req_valid && sts.req_query) begin
          state_next = sts.req_ok ? S_RD1 : S_DONE;
        end
      end
      S_RD1: begin
        state_next = S_RD2;
      end
      S_RD2: begin
        ctl.rd_hi  = 1'b1;
        ctl.cap_a  = 1'b1;
        state_next = S_RD3;
      end
      S_RD3: begin
        ctl.cap_b  = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        ctl.diff   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        ctl.sq_step = 1'b1;
        if (sts.sq_last) begin
          state_next = S_ROOT_INIT;
        end
      end
      S_ROOT_INIT: begin
        ctl.root_init = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        ctl.root_step = 1'b1;
        if (sts.root_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
